FILE: rtl/core/sapq_pkg.sv
// Shared types and constants of the sorted-array priority queue.
`default_nettype none

package sapq_pkg;

  localparam int VAL_W  = 16;
  localparam int PRI_W  = 8;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  // Operation kind of an input item.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sapq_if.sv
// Handshake channel interfaces for queue operations and their results.
`default_nettype none

interface sapq_in_if;
  import sapq_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [VAL_W-1:0] item_value;
  logic [PRI_W-1:0] item_priority;

  modport source (output valid, kind, item_value, item_priority, input ready);
  modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

interface sapq_out_if;
  import sapq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  out_value;
  logic [PRI_W-1:0]  out_priority;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, status, out_value, out_priority, fill_count, input ready);
  modport sink   (input valid, status, out_value, out_priority, fill_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sapq_ctrl.sv
// Controller state machine: captures an item, then runs it when the result register is free.
`default_nettype none

module sapq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sapq_pkg::dp_stat_t  stat,
  output sapq_pkg::dp_cmd_t   cmd
);
  import sapq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // The previous result must have left the output register or be taken in this cycle.
        if (!stat.out_hold) begin
          cmd.exec  = 1'b1;
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  ast_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == CS_EXEC))
    else $error("accepted item did not move controller to execute");

  ast_exec_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!stat.out_hold && state_r == CS_EXEC))
    else $error("execute issued while result register occupied");

  ast_no_ready_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_EXEC) |-> !in_ready)
    else $error("new item taken while one is still pending");

endmodule

`default_nettype wire

FILE: rtl/core/sapq_datapath.sv
// Datapath: sorted slot array with parallel compare, entry count and result register.
`default_nettype none

module sapq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  sapq_pkg::dp_cmd_t            cmd,
  output sapq_pkg::dp_stat_t           stat,
  input  wire                          in_kind,
  input  wire  [sapq_pkg::VAL_W-1:0]   in_item_value,
  input  wire  [sapq_pkg::PRI_W-1:0]   in_item_priority,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic [sapq_pkg::STAT_W-1:0]  out_status,
  output logic [sapq_pkg::VAL_W-1:0]   out_value,
  output logic [sapq_pkg::PRI_W-1:0]   out_priority,
  output logic [sapq_pkg::FILL_W-1:0]  out_fill_count
);
  import sapq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Slot 0 holds the entry with the smallest priority number; the
  // order rises with the slot index up to cnt_r - 1.
  logic [VAL_W-1:0]  val_r [DEPTH];
  logic [PRI_W-1:0]  pri_r [DEPTH];
  logic [CW-1:0]     cnt_r;

  logic              kind_r;
  logic [VAL_W-1:0]  ival_r;
  logic [PRI_W-1:0]  ipri_r;

  logic              ovalid_r;
  logic [STAT_W-1:0] ostat_r;
  logic [VAL_W-1:0]  oval_r;
  logic [PRI_W-1:0]  opri_r;
  logic [FILL_W-1:0] ofill_r;

  logic              full, empty;
  logic [DEPTH-1:0]  lt;
  logic [VAL_W-1:0]  ins_val [DEPTH];
  logic [PRI_W-1:0]  ins_pri [DEPTH];
  logic [VAL_W-1:0]  rem_val [DEPTH];
  logic [PRI_W-1:0]  rem_pri [DEPTH];
  logic [CW-1:0]     cnt_nxt;
  logic [STAT_W-1:0] stat_nxt;
  logic              do_ins, do_rem;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  assign do_ins = cmd.exec && (kind_r == KIND_INSERT) && !full;
  assign do_rem = cmd.exec && (kind_r == KIND_REMOVE) && !empty;

  // Stored entries that rank below the new one form a prefix of the array;
  // they stay put, the new entry lands just above them, the rest move up.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      lt[j] = (CW'(j) < cnt_r) && (pri_r[j] < ipri_r);
    end
    ins_val[0] = lt[0] ? val_r[0] : ival_r;
    ins_pri[0] = lt[0] ? pri_r[0] : ipri_r;
    for (int j = 1; j < DEPTH; j++) begin
      if (lt[j]) begin
        ins_val[j] = val_r[j];
        ins_pri[j] = pri_r[j];
      end else if (lt[j-1]) begin
        ins_val[j] = ival_r;
        ins_pri[j] = ipri_r;
      end else begin
        ins_val[j] = val_r[j-1];
        ins_pri[j] = pri_r[j-1];
      end
    end
    for (int j = 0; j < DEPTH - 1; j++) begin
      rem_val[j] = val_r[j+1];
      rem_pri[j] = pri_r[j+1];
    end
    rem_val[DEPTH-1] = val_r[DEPTH-1];
    rem_pri[DEPTH-1] = pri_r[DEPTH-1];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (kind_r == KIND_INSERT) begin
      stat_nxt = full ? ST_FULL : ST_OK;
      if (!full) cnt_nxt = CW'(cnt_r + 1'b1);
    end else begin
      stat_nxt = empty ? ST_EMPTY : ST_OK;
      if (!empty) cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      ival_r <= in_item_value;
      ipri_r <= in_item_priority;
    end
    if (do_ins) begin
      for (int j = 0; j < DEPTH; j++) begin
        val_r[j] <= ins_val[j];
        pri_r[j] <= ins_pri[j];
      end
    end else if (do_rem) begin
      for (int j = 0; j < DEPTH; j++) begin
        val_r[j] <= rem_val[j];
        pri_r[j] <= rem_pri[j];
      end
    end
    if (cmd.exec) begin
      ostat_r <= stat_nxt;
      oval_r  <= do_rem ? val_r[0] : '0;
      opri_r  <= do_rem ? pri_r[0] : '0;
      ofill_r <= FILL_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        cnt_r    <= cnt_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign stat.out_hold  = ovalid_r && !out_ready;
  assign out_valid      = ovalid_r;
  assign out_status     = ostat_r;
  assign out_value      = oval_r;
  assign out_priority   = opri_r;
  assign out_fill_count = ofill_r;

  ast_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  ast_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (cnt_r == CW'($past(cnt_r) + 1'b1)))
    else $error("accepted insert did not raise the entry count");

  ast_bottom_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CW'(2)) |-> (pri_r[0] <= pri_r[1]))
    else $error("lowest two slots out of priority order");

endmodule

`default_nettype wire

FILE: rtl/core/sorted_array_priority_queue_unit.sv
// Top level of the sorted-array priority queue.
// Each item is an insert (value and priority) or a remove, and gives exactly one
// result item: a status, the removed entry (zero unless a remove succeeded) and the
// fill count after the operation. The remove returns the entry with the smallest
// priority number; among equal priorities the entry inserted last leaves first. An
// insert into a full queue reports full and changes nothing, a remove from an empty
// queue reports empty. Each item is captured first; then, once no untaken result holds
// the output, all DEPTH slots are compared in parallel and shifted while the result
// register loads. Another item may be accepted while the previous result still waits,
// but not while a captured item still waits to execute.
`default_nettype none

module sorted_array_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input wire          clk,
  input wire          rst_n,
  sapq_in_if.sink     in_chan,
  sapq_out_if.source  out_chan
);
  import sapq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sapq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_chan.kind),
    .in_item_value    (in_chan.item_value),
    .in_item_priority (in_chan.item_priority),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_status       (out_chan.status),
    .out_value        (out_chan.out_value),
    .out_priority     (out_chan.out_priority),
    .out_fill_count   (out_chan.fill_count)
  );

endmodule

`default_nettype wire
